// ----- hdl/mmc2_pkg.sv -----
// ----------------------------------------------------------------------------
// mmc2_pkg
// Shared codes and constants of the MMC2 bank mapper: access opcodes, target
// codes, configuration register indexes and address decode constants.
// ----------------------------------------------------------------------------
package mmc2_pkg;

  // Access kinds carried on the input stream
  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_PPU_READ  = 2'd2,
    OP_PPU_WRITE = 2'd3
  } opcode_e;

  // Memory reached by an access
  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR     = 3'd3,
    TGT_OPEN    = 3'd4
  } target_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRG_BANK_COUNT  = 2'd0,
    CFG_CHR_BANK_COUNT  = 2'd1,
    CFG_PRG_RAM_PRESENT = 2'd2,
    CFG_CHR_IS_RAM      = 2'd3
  } cfg_index_e;

  localparam int unsigned BankW   = 8;
  localparam int unsigned RegValW = 5;
  localparam int unsigned OffsetW = 21;

  // Configuration reset values
  localparam logic [BankW-1:0] PrgBankCountReset = 8'd16;
  localparam logic [BankW-1:0] ChrBankCountReset = 8'd32;

  // Tile fetch addresses that flip the CHR latches
  localparam logic [15:0] TileKeyMask = 16'h1FF8;
  localparam logic [15:0] TileLowFd   = 16'h0FD8;
  localparam logic [15:0] TileLowFe   = 16'h0FE8;
  localparam logic [15:0] TileHighFd  = 16'h1FD8;
  localparam logic [15:0] TileHighFe  = 16'h1FE8;

  // CPU window boundaries
  localparam logic [15:0] PrgRamBase = 16'h6000;
  localparam logic [15:0] RegBase    = 16'hA000;

  // Fixed PRG banks sit at count - 8 + addr[15:13]
  localparam logic [BankW-1:0] FixedBankBias = 8'd8;

endpackage

// ----- hdl/mmc2_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// mmc2_bank_mapper
// MMC2 address decoder and bank switcher: one bus access in, one mapping
// result out.
// ----------------------------------------------------------------------------
// One access at a time. An access that needs a banked lookup (PRG ROM read,
// CHR read or CHR RAM write with a nonzero bank count) first reduces the
// bank modulo the bank count in the shared one-bit-per-cycle unit, then forms
// the offset into the result register. Other accesses present their result
// in the cycle after transfer. The input is ready again in the cycle after
// the result is transferred out, so no new access is taken before the last
// result has left. Register writes and latch flips take effect at input
// transfer, so the mirror_mode of a result already reflects a mirroring write
// in the same access. Configuration must be written through cfg_we_i only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mmc2_bank_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Access stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // bus_address[15:0], write_data[23:16]
  input  logic [1:0]  s_axis_tuser_i,  // opcode[1:0]
  // Mapping result out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // handled[0], target[3:1], mem_offset[24:4], write_strobe[25],
  // data_out[33:26], mirror_mode[34], zero[39:35]
  output logic [39:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

  localparam int unsigned BankW = mmc2_pkg::BankW;

  // Configuration
  logic [BankW-1:0] prg_count_q;
  logic [BankW-1:0] chr_count_q;
  logic             prg_ram_present_q;
  logic             chr_is_ram_q;

  // Mapper state
  logic [mmc2_pkg::RegValW-1:0] prg_select_q;
  logic [mmc2_pkg::RegValW-1:0] chr_low_fd_q;
  logic [mmc2_pkg::RegValW-1:0] chr_low_fe_q;
  logic [mmc2_pkg::RegValW-1:0] chr_high_fd_q;
  logic [mmc2_pkg::RegValW-1:0] chr_high_fe_q;
  logic                         mirror_bit_q;
  logic                         latch_low_q;
  logic                         latch_high_q;

  // Sequencer and pending result
  state_e                         state_q;
  logic                           out_valid_q;
  logic                           handled_q;
  mmc2_pkg::target_e              target_q;
  logic [mmc2_pkg::OffsetW-1:0]   offset_q;
  logic                           strobe_q;
  logic [7:0]                     data_q;
  logic [12:0]                    low_q;
  logic                           is_prg_q;

  // Input fields
  mmc2_pkg::opcode_e op;
  logic [15:0]       addr;
  logic [7:0]        wdata;
  logic              accept;

  // Decode results
  logic                         dec_handled;
  mmc2_pkg::target_e            dec_target;
  logic [mmc2_pkg::OffsetW-1:0] dec_offset;
  logic                         dec_strobe;
  logic                         dec_need_mod;
  logic                         dec_is_prg;
  logic                         dec_reg_write;
  logic                         dec_flip;
  logic [BankW-1:0]             dec_dividend;
  logic [BankW-1:0]             dec_divisor;
  logic [mmc2_pkg::RegValW-1:0] chr_bank;
  logic [BankW-1:0]             fixed_bank;

  logic             mod_done;
  logic [BankW-1:0] mod_rem;

  assign op     = mmc2_pkg::opcode_e'(s_axis_tuser_i);
  assign addr   = s_axis_tdata_i[15:0];
  assign wdata  = s_axis_tdata_i[23:16];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Select the CHR bank from the latch of the addressed half
  always_comb begin
    if (!addr[12]) begin
      chr_bank = latch_low_q ? chr_low_fe_q : chr_low_fd_q;
    end else begin
      chr_bank = latch_high_q ? chr_high_fe_q : chr_high_fd_q;
    end
  end

  // Last three PRG banks, wrapping modulo 256
  assign fixed_bank = prg_count_q + {5'd0, addr[15:13]} - mmc2_pkg::FixedBankBias;

  // Decode one access
  always_comb begin
    dec_handled   = 1'b0;
    dec_target    = mmc2_pkg::TGT_NONE;
    dec_offset    = '0;
    dec_strobe    = 1'b0;
    dec_need_mod  = 1'b0;
    dec_is_prg    = 1'b0;
    dec_reg_write = 1'b0;
    dec_flip      = 1'b0;
    dec_dividend  = {3'd0, chr_bank};
    dec_divisor   = chr_count_q;
    case (op) inside
      mmc2_pkg::OP_CPU_READ, mmc2_pkg::OP_CPU_WRITE: begin
        if (addr[15:13] == mmc2_pkg::PrgRamBase[15:13]) begin
          if (prg_ram_present_q) begin
            dec_handled = 1'b1;
            dec_target  = mmc2_pkg::TGT_PRG_RAM;
            dec_offset  = {8'd0, addr[12:0]};
            dec_strobe  = (op == mmc2_pkg::OP_CPU_WRITE);
          end
        end else if (op == mmc2_pkg::OP_CPU_READ && addr[15]) begin
          dec_handled = 1'b1;
          if (prg_count_q == '0) begin
            dec_target = mmc2_pkg::TGT_OPEN;
          end else begin
            dec_target   = mmc2_pkg::TGT_PRG_ROM;
            dec_need_mod = 1'b1;
            dec_is_prg   = 1'b1;
            dec_divisor  = prg_count_q;
            dec_dividend = (addr < mmc2_pkg::RegBase) ? {3'd0, prg_select_q} : fixed_bank;
          end
        end else if (op == mmc2_pkg::OP_CPU_WRITE && addr >= mmc2_pkg::RegBase) begin
          dec_handled   = 1'b1;
          dec_reg_write = 1'b1;
        end
      end
      default: begin
        if (addr[15:13] == 3'd0) begin
          if (op == mmc2_pkg::OP_PPU_READ) begin
            dec_handled = 1'b1;
            dec_flip    = 1'b1;
            if (chr_count_q == '0) begin
              dec_target = mmc2_pkg::TGT_OPEN;
            end else begin
              dec_target   = mmc2_pkg::TGT_CHR;
              dec_need_mod = 1'b1;
            end
          end else if (chr_is_ram_q) begin
            dec_handled = 1'b1;
            if (chr_count_q != '0) begin
              dec_target   = mmc2_pkg::TGT_CHR;
              dec_need_mod = 1'b1;
              dec_strobe   = 1'b1;
            end
          end
        end
      end
    endcase
  end

  // Shared bank-count remainder unit
  mmc2_bank_mod u_bank_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && dec_need_mod),
    .dividend_i (dec_dividend),
    .divisor_i  (dec_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Sequencer, mapper registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      out_valid_q       <= 1'b0;
      handled_q         <= 1'b0;
      target_q          <= mmc2_pkg::TGT_NONE;
      offset_q          <= '0;
      strobe_q          <= 1'b0;
      data_q            <= 8'd0;
      low_q             <= '0;
      is_prg_q          <= 1'b0;
      prg_count_q       <= mmc2_pkg::PrgBankCountReset;
      chr_count_q       <= mmc2_pkg::ChrBankCountReset;
      prg_ram_present_q <= 1'b1;
      chr_is_ram_q      <= 1'b0;
      prg_select_q      <= '0;
      chr_low_fd_q      <= '0;
      chr_low_fe_q      <= '0;
      chr_high_fd_q     <= '0;
      chr_high_fe_q     <= '0;
      mirror_bit_q      <= 1'b0;
      latch_low_q       <= 1'b0;
      latch_high_q      <= 1'b0;
    end else begin
      // Load configuration
      if (cfg_we_i) begin
        unique case (mmc2_pkg::cfg_index_e'(cfg_index_i))
          mmc2_pkg::CFG_PRG_BANK_COUNT:  prg_count_q       <= cfg_data_i;
          mmc2_pkg::CFG_CHR_BANK_COUNT:  chr_count_q       <= cfg_data_i;
          mmc2_pkg::CFG_PRG_RAM_PRESENT: prg_ram_present_q <= cfg_data_i[0];
          mmc2_pkg::CFG_CHR_IS_RAM:      chr_is_ram_q      <= cfg_data_i[0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // Load a mapper register on a CPU register write
            if (dec_reg_write) begin
              unique case (addr[14:12])
                3'd2: prg_select_q  <= wdata[4:0];
                3'd3: chr_low_fd_q  <= wdata[4:0];
                3'd4: chr_low_fe_q  <= wdata[4:0];
                3'd5: chr_high_fd_q <= wdata[4:0];
                3'd6: chr_high_fe_q <= wdata[4:0];
                3'd7: mirror_bit_q  <= wdata[0];
                default: ;
              endcase
            end
            // Flip latches after the lookup has used them
            if (dec_flip) begin
              if ((addr & mmc2_pkg::TileKeyMask) == mmc2_pkg::TileLowFd) begin
                latch_low_q <= 1'b0;
              end else if ((addr & mmc2_pkg::TileKeyMask) == mmc2_pkg::TileLowFe) begin
                latch_low_q <= 1'b1;
              end else if ((addr & mmc2_pkg::TileKeyMask) == mmc2_pkg::TileHighFd) begin
                latch_high_q <= 1'b0;
              end else if ((addr & mmc2_pkg::TileKeyMask) == mmc2_pkg::TileHighFe) begin
                latch_high_q <= 1'b1;
              end
            end
            handled_q <= dec_handled;
            target_q  <= dec_target;
            offset_q  <= dec_offset;
            strobe_q  <= dec_strobe;
            data_q    <= dec_strobe ? wdata : 8'd0;
            low_q     <= addr[12:0];
            is_prg_q  <= dec_is_prg;
            if (dec_need_mod) begin
              state_q <= ST_DIVIDE;
            end else begin
              state_q     <= ST_OUTPUT;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_DIVIDE: begin
          // Assemble the physical offset from the reduced bank
          if (mod_done) begin
            if (is_prg_q) begin
              offset_q <= {mod_rem, low_q};
            end else begin
              offset_q <= {1'b0, mod_rem, low_q[11:0]};
            end
            state_q     <= ST_OUTPUT;
            out_valid_q <= 1'b1;
          end
        end
        ST_OUTPUT: begin
          // Hold the result until transfer
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, ~mirror_bit_q, data_q, strobe_q, offset_q,
                            target_q, handled_q};

endmodule

// ----- hdl/mmc2_bank_mod.sv -----
// ----------------------------------------------------------------------------
// mmc2_bank_mod
// Iterative 8-bit remainder unit: reduces a bank number modulo a bank count,
// one quotient bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module mmc2_bank_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mmc2_pkg::BankW-1:0]  dividend_i,
  input  logic [mmc2_pkg::BankW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [mmc2_pkg::BankW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(mmc2_pkg::BankW);

  logic                       busy_q;
  logic                       done_q;
  logic [CntW-1:0]            cnt_q;
  logic [mmc2_pkg::BankW-1:0] rem_q, rem_d;
  logic [mmc2_pkg::BankW-1:0] dvd_q;
  logic [mmc2_pkg::BankW-1:0] dsr_q;
  logic [mmc2_pkg::BankW:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[mmc2_pkg::BankW-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = mmc2_pkg::BankW'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[mmc2_pkg::BankW-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(mmc2_pkg::BankW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[mmc2_pkg::BankW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
